### rtl/bbc_pkg.sv
// ============================================================================
// bbc_pkg
// Shared types and constants of the B-spline to Bezier converter: queue
// status, layout of a segment job (four points by three coordinates).
// ============================================================================
`default_nettype none

package bbc_pkg;

  // points per segment and coordinates per point
  localparam int SEG_POINTS = 4;
  localparam int NUM_COORDS = 3;
  localparam int NUM_PTS    = SEG_POINTS * NUM_COORDS;

  // job slot index of a coordinate's oldest point, then +0..+3
  localparam int PT_X = 0;
  localparam int PT_Y = SEG_POINTS;
  localparam int PT_Z = 2 * SEG_POINTS;

  // segment job queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } bbc_q_status_t;

endpackage

`default_nettype wire

### rtl/bbc_if.sv
// ============================================================================
// bbc_if
// Valid/ready channels of the converter: de Boor points in, Bezier points
// out.
// ============================================================================
`default_nettype none

interface bbc_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          curve_start;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, curve_start, point_x, point_y, point_z, input ready);
  modport sink   (input valid, curve_start, point_x, point_y, point_z, output ready);
endinterface

interface bbc_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] bezier_x;
  logic signed [COORD_WIDTH-1:0] bezier_y;
  logic signed [COORD_WIDTH-1:0] bezier_z;
  logic                          last_of_run;

  modport source (output valid, bezier_x, bezier_y, bezier_z, last_of_run, input ready);
  modport sink   (input valid, bezier_x, bezier_y, bezier_z, last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/bspline_to_bezier_convert_core.sv
// ============================================================================
// bspline_to_bezier_convert_core
// Uniform cubic B-spline to Bezier converter, top level.
// ============================================================================
// Takes 3-D de Boor points in signed fixed point (Q16.16 at a COORD_WIDTH of
// 32) and emits the Bezier points of each cubic segment: b0..b3 for the first
// segment of a curve, b1..b3 for later ones, each the floor of its weighted
// sum over six; last_of_run marks the final point of a segment. A curve of
// fewer than four points emits nothing, and the first point after reset
// opens a curve. The back end produces one Bezier point per cycle while the
// output is not stalled by a low ready. A two-entry segment queue lets
// input be taken while results wait on the output. With an idle output a
// first result passes from the queue through the stage-1 and stage-2
// registers into the output register.
// ============================================================================
`default_nettype none

module bspline_to_bezier_convert_core
  import bbc_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  bbc_in_if.sink    in_ch,
  bbc_out_if.source out_ch
);

  localparam int JOB_WIDTH = 1 + NUM_PTS * COORD_WIDTH;

  bbc_q_status_t                       q_status;
  logic                                job_push;
  logic                                job_first;
  logic [NUM_PTS-1:0][COORD_WIDTH-1:0] job_pts;
  logic                                job_pop;
  logic [JOB_WIDTH-1:0]                head_data;
  logic                                head_first;
  logic [NUM_PTS-1:0][COORD_WIDTH-1:0] head_pts;

  // point intake and window
  bbc_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_status  (q_status),
    .job_push  (job_push),
    .job_first (job_first),
    .job_pts   (job_pts)
  );

  // segment job queue
  bbc_queue #(
    .DATA_WIDTH (JOB_WIDTH),
    .DEPTH      (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data ({job_first, job_pts}),
    .pop       (job_pop),
    .head_data (head_data),
    .status    (q_status)
  );

  assign head_first = head_data[JOB_WIDTH-1];
  assign head_pts   = head_data[JOB_WIDTH-2:0];

  // row blending and output register
  bbc_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .head_first (head_first),
    .head_pts   (head_pts),
    .pop        (job_pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### rtl/bbc_front.sv
// ============================================================================
// bbc_front
// Accepts de Boor points, keeps the three-point window and point count of
// the current curve, and pushes one segment job per point from the fourth.
// ============================================================================
`default_nettype none

module bbc_front
  import bbc_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  bbc_in_if.sink                                in_ch,
  input  bbc_q_status_t                         q_status,
  output logic                                  job_push,
  output logic                                  job_first,
  output logic [NUM_PTS-1:0][COORD_WIDTH-1:0]   job_pts
);

  typedef logic [2:0] seen_t;

  localparam seen_t SEEN_FIRST_SEG = 3'd3;
  localparam seen_t SEEN_FULL      = 3'd4;

  logic [2:0][COORD_WIDTH-1:0] win_x_r;
  logic [2:0][COORD_WIDTH-1:0] win_y_r;
  logic [2:0][COORD_WIDTH-1:0] win_z_r;
  seen_t                       seen_r;
  seen_t                       seen_nxt;
  seen_t                       seen_eff;
  logic                        accept;

  // take an item whenever the job queue has room
  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // a start mark restarts the count; stale window entries are never read
  assign seen_eff  = in_ch.curve_start ? '0 : seen_r;
  assign seen_nxt  = (seen_eff < SEEN_FULL) ? seen_eff + 3'd1 : seen_eff;
  assign job_push  = accept && (seen_eff >= SEEN_FIRST_SEG);
  assign job_first = (seen_eff == SEEN_FIRST_SEG);

  // segment job: window oldest first, then the new point
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      job_pts[PT_X + k] = win_x_r[k];
      job_pts[PT_Y + k] = win_y_r[k];
      job_pts[PT_Z + k] = win_z_r[k];
    end
    job_pts[PT_X + 3] = in_ch.point_x;
    job_pts[PT_Y + 3] = in_ch.point_y;
    job_pts[PT_Z + 3] = in_ch.point_z;
  end

  // point count of the current curve
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (accept) begin
      seen_r <= seen_nxt;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (accept) begin
      win_x_r <= {in_ch.point_x, win_x_r[2:1]};
      win_y_r <= {in_ch.point_y, win_y_r[2:1]};
      win_z_r <= {in_ch.point_z, win_z_r[2:1]};
    end
  end

endmodule

`default_nettype wire

### rtl/bbc_queue.sv
// ============================================================================
// bbc_queue
// Small register FIFO of segment jobs between the front and back end.
// ============================================================================
`default_nettype none

module bbc_queue
  import bbc_pkg::*;
#(
  parameter int DATA_WIDTH = 8,
  parameter int DEPTH      = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic                  pop,
  output logic [DATA_WIDTH-1:0] head_data,
  output bbc_q_status_t         status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]         wr_ptr_r;
  logic [PW-1:0]         rd_ptr_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head_data    = slot_r[rd_ptr_r];

  // occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("job popped from empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

### rtl/bbc_back.sv
// ============================================================================
// bbc_back
// Runs the Bezier rows of the head segment job, one row per cycle while
// the output is not stalled, through a blend sum stage, a divide-by-three
// multiply stage and a combine stage into the output register.
// ============================================================================
`default_nettype none

module bbc_back
  import bbc_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bbc_q_status_t                       q_status,
  input  logic                                head_first,
  input  logic [NUM_PTS-1:0][COORD_WIDTH-1:0] head_pts,
  output logic                                pop,
  bbc_out_if.source                           out_ch
);

  typedef enum logic [1:0] {ROW_B0, ROW_B1, ROW_B2, ROW_B3} row_t;

  localparam int W  = COORD_WIDTH;
  // blend sum, sum/2 shifted positive, and its low (even) and high split
  localparam int SW = W + 4;
  localparam int UW = W + 2;
  localparam int LW = 2 * ((UW + 2) / 4);
  localparam int HW = UW - LW;

  // x / 3 == (x * ceil(2^(n+1)/3)) >> (n+1) for any n-bit x
  localparam logic [HW+1:0] MH_WIDE = ({1'b1, {(HW + 1){1'b0}}} + (HW + 2)'(2))
                                      / (HW + 2)'(3);
  localparam logic [LW+1:0] ML_WIDE = ({1'b1, {(LW + 1){1'b0}}} + (LW + 2)'(2))
                                      / (LW + 2)'(3);
  localparam logic [HW-1:0] MH = MH_WIDE[HW-1:0];
  localparam logic [LW-1:0] ML = ML_WIDE[LW-1:0];
  // (2^LW - 1) / 3, exact since LW is even
  localparam logic [LW:0]   C_WIDE = ({1'b1, {LW{1'b0}}} - (LW + 1)'(1)) / (LW + 1)'(3);
  localparam logic [LW-1:0] C3 = C_WIDE[LW-1:0];
  // shifts floor(s/2) into the non-negative range
  localparam logic [UW-1:0] OFFSET = UW'(3) << (W - 1);

  logic adv;
  logic issue;
  row_t row_r;
  row_t row_nxt;
  row_t cur_row;

  logic [2:0][SW-1:0] sum_nxt;
  logic [2:0][SW-1:0] s1_sum_r;
  logic               s1_valid_r;
  logic               s1_last_r;

  logic [2:0][UW-1:0]     u_c;
  logic [2:0][2*HW-1:0]   ph_c;
  logic [2:0][2*LW-1:0]   pl_c;
  logic [2:0][HW-1:0]     s2_h_r;
  logic [2:0][LW-1:0]     s2_l_r;
  logic [2:0][HW-2:0]     s2_qh_r;
  logic [2:0][LW-2:0]     s2_ql_r;
  logic                   s2_valid_r;
  logic                   s2_last_r;

  logic [2:0][HW-1:0] rh_full;
  logic [2:0][LW-1:0] rl_full;
  logic [2:0][1:0]    rh_c;
  logic [2:0][1:0]    rl_c;
  logic [2:0][LW:0]   rc_c;
  logic [2:0]         wrap_c;
  logic [2:0][UW-1:0] q_c;
  logic [2:0][W-1:0]  res_c;

  logic               out_valid_r;
  logic               out_last_r;
  logic [2:0][W-1:0]  out_pt_r;

  // the whole pipeline moves when the output register can take a point
  assign adv   = !out_valid_r || out_ch.ready;
  assign issue = adv && !q_status.empty;

  // a later segment skips b0, which equals the previous b3
  assign cur_row = (row_r == ROW_B0 && !head_first) ? ROW_B1 : row_r;
  assign row_nxt = (cur_row == ROW_B3) ? ROW_B0 : row_t'(cur_row + 2'd1);
  assign pop     = issue && (cur_row == ROW_B3);

  // stage 1: blend sum of the current row, exact
  always_comb begin
    logic [SW-1:0] f0, f1, f2, f3;
    for (int c = 0; c < 3; c++) begin
      f0 = {{4{head_pts[c*SEG_POINTS][W-1]}},     head_pts[c*SEG_POINTS]};
      f1 = {{4{head_pts[c*SEG_POINTS + 1][W-1]}}, head_pts[c*SEG_POINTS + 1]};
      f2 = {{4{head_pts[c*SEG_POINTS + 2][W-1]}}, head_pts[c*SEG_POINTS + 2]};
      f3 = {{4{head_pts[c*SEG_POINTS + 3][W-1]}}, head_pts[c*SEG_POINTS + 3]};
      case (cur_row)
        ROW_B0:  sum_nxt[c] = f0 + {f1[SW-3:0], 2'b00} + f2;
        ROW_B1:  sum_nxt[c] = {f1[SW-3:0], 2'b00} + {f2[SW-2:0], 1'b0};
        ROW_B2:  sum_nxt[c] = {f1[SW-2:0], 1'b0} + {f2[SW-3:0], 2'b00};
        ROW_B3:  sum_nxt[c] = f1 + {f2[SW-3:0], 2'b00} + f3;
        default: sum_nxt[c] = '0;
      endcase
    end
  end

  // stage 2: u = floor(s/2) + offset, split, divide each half by three
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      u_c[c]  = s1_sum_r[c][UW:1] + OFFSET;
      ph_c[c] = {{HW{1'b0}}, u_c[c][UW-1:LW]} * {{HW{1'b0}}, MH};
      pl_c[c] = {{LW{1'b0}}, u_c[c][LW-1:0]} * {{LW{1'b0}}, ML};
    end
  end

  // stage 3: remainders, recombine the halves, undo the offset
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rh_full[c] = s2_h_r[c] - ({s2_qh_r[c], 1'b0} + {1'b0, s2_qh_r[c]});
      rl_full[c] = s2_l_r[c] - ({s2_ql_r[c], 1'b0} + {1'b0, s2_ql_r[c]});
      rh_c[c]    = rh_full[c][1:0];
      rl_c[c]    = rl_full[c][1:0];
      case (rh_c[c])
        2'd1:    rc_c[c] = {1'b0, C3};
        2'd2:    rc_c[c] = {C3, 1'b0};
        default: rc_c[c] = '0;
      endcase
      wrap_c[c] = ({1'b0, rh_c[c]} + {1'b0, rl_c[c]}) >= 3'd3;
      q_c[c]    = {1'b0, s2_qh_r[c], {LW{1'b0}}} + UW'(rc_c[c]) + UW'(s2_ql_r[c])
                  + UW'(wrap_c[c]);
      res_c[c]  = q_c[c][W-1:0] ^ {1'b1, {(W - 1){1'b0}}};
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= ROW_B0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (issue) begin
        row_r <= row_nxt;
      end
      s1_valid_r  <= issue;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum_r   <= sum_nxt;
      s1_last_r  <= (cur_row == ROW_B3);
      s2_last_r  <= s1_last_r;
      out_last_r <= s2_last_r;
      out_pt_r   <= res_c;
      for (int c = 0; c < 3; c++) begin
        s2_h_r[c]  <= u_c[c][UW-1:LW];
        s2_l_r[c]  <= u_c[c][LW-1:0];
        s2_qh_r[c] <= ph_c[c][2*HW-1:HW+1];
        s2_ql_r[c] <= pl_c[c][2*LW-1:LW+1];
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.bezier_x    = out_pt_r[0];
  assign out_ch.bezier_y    = out_pt_r[1];
  assign out_ch.bezier_z    = out_pt_r[2];
  assign out_ch.last_of_run = out_last_r;

`ifndef ASSERT_OFF
  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (row_r == ROW_B0))
    else $error("row counter did not restart after the last row");

  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (s1_valid_r && s1_last_r))
    else $error("job retired without its last row in flight");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(row_r) && $stable(s1_valid_r) && $stable(s2_valid_r)))
    else $error("pipeline moved while output stalled");
`endif

endmodule

`default_nettype wire

### tb/bspline_to_bezier_convert_core_tb.sv
// ============================================================================
// bspline_to_bezier_convert_core_tb
// Self-checking bench for the B-spline to Bezier converter.
// ============================================================================
// Streams de Boor points into the core over its valid/ready channel. A
// tracker object keeps its own window of the curve and works out the Bezier
// points that each accepted point must produce. Every result taken from the
// output channel is compared field by field with the oldest point due.
// A directed opening covers coordinate extremes, floor rounding of negative
// sums, short curves, repeated start marks and a curve opened without a
// start mark. Random curves follow, with idle gaps on the input and stalls
// on the output that come and go between curves.
// ============================================================================

module bspline_to_bezier_convert_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW          = 32;
  localparam int RAND_POINTS = 350;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = 32'sh8000_0000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } bez_pt_t;

  // tracks the curve window and the Bezier points still owed by the core
  class bezier_tracker;
    coord_t  win_x[3];
    coord_t  win_y[3];
    coord_t  win_z[3];
    bit [2:0] seen;
    bez_pt_t due[$];
    int      errors;
    int      n_points;
    int      n_curves;
    int      n_checked;

    function new();
      clear_window();
      seen      = '0;
      errors    = 0;
      n_points  = 0;
      n_curves  = 0;
      n_checked = 0;
    endfunction

    function void clear_window();
      for (int i = 0; i < 3; i++) begin
        win_x[i] = '0;
        win_y[i] = '0;
        win_z[i] = '0;
      end
    endfunction

    // floor of weighted sum over six, exact in 64 bits
    function coord_t blend(int row, coord_t w[3], coord_t newest);
      int     wt[4][4];
      longint s;
      longint q;
      wt = '{'{1, 4, 1, 0}, '{0, 4, 2, 0}, '{0, 2, 4, 0}, '{0, 1, 4, 1}};
      s = longint'(wt[row][0]) * longint'(w[0]) + longint'(wt[row][1]) * longint'(w[1])
        + longint'(wt[row][2]) * longint'(w[2]) + longint'(wt[row][3]) * longint'(newest);
      q = s / 6;
      if ((s % 6) != 0 && s < 0)
        q = q - 1;
      return coord_t'(q);
    endfunction

    function void take_control_point(bit start, coord_t x, coord_t y, coord_t z);
      bez_pt_t p;
      int      first_row;
      n_points++;
      if (start) begin
        clear_window();
        seen = '0;
      end
      if (seen == 0)
        n_curves++;
      // fourth point onward closes a segment
      if (seen >= 3) begin
        first_row = (seen == 3) ? 0 : 1;
        for (int r = first_row; r < 4; r++) begin
          p.x    = blend(r, win_x, x);
          p.y    = blend(r, win_y, y);
          p.z    = blend(r, win_z, z);
          p.last = (r == 3);
          due    = {due, p};
        end
      end
      // shift window, oldest first
      win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = x;
      win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = y;
      win_z[0] = win_z[1]; win_z[1] = win_z[2]; win_z[2] = z;
      if (seen < 4)
        seen++;
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_bezier_point(bez_pt_t got);
      bez_pt_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected bezier point, expected none, actual (%0d, %0d, %0d) last %0b",
                   $time, got.x, got.y, got.z, got.last);
        return;
      end
      want = due.pop_front();
      n_checked++;
      if (got.x !== want.x)
        report("bezier_x", want.x, got.x);
      if (got.y !== want.y)
        report("bezier_y", want.y, got.y);
      if (got.z !== want.z)
        report("bezier_z", want.z, got.z);
      if (got.last !== want.last)
        report("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  bit   in_gaps_on;
  bit   out_stalls_on;
  int   stall_left;

  bezier_tracker trk = new();

  bbc_in_if  #(.COORD_WIDTH(CW)) in_ch();
  bbc_out_if #(.COORD_WIDTH(CW)) out_ch();

  bspline_to_bezier_convert_core #(.COORD_WIDTH(CW)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_gap(bit enabled);
    int r;
    if (!enabled)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // coordinate mix: extremes, small values, small Q16.16 values, full range
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return CMAX;
      1:       return CMIN;
      2:       return coord_t'(int'($urandom_range(0, 16)) - 8);
      3, 4:    return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return coord_t'($urandom);
    endcase
  endfunction

  // present one point and hold it until accepted
  task automatic send_point(bit start, coord_t x, coord_t y, coord_t z);
    int gap;
    gap = idle_gap(in_gaps_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.curve_start <= start;
    in_ch.point_x     <= x;
    in_ch.point_y     <= y;
    in_ch.point_z     <= z;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_curve(int len, bit open_mark);
    for (int i = 0; i < len; i++) begin
      // stray restart marks inside a curve now and then
      if (i == 0)
        send_point(open_mark, rand_coord(), rand_coord(), rand_coord());
      else
        send_point($urandom_range(0, 39) == 0, rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // output ready with random stalls
  always @(posedge clk) begin
    if (!out_stalls_on) begin
      out_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 30)
        stall_left <= idle_gap(1'b1);
    end
  end

  // note accepted points, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        trk.take_control_point(in_ch.curve_start, in_ch.point_x, in_ch.point_y,
                               in_ch.point_z);
      if (out_ch.valid && out_ch.ready)
        trk.check_bezier_point('{x: out_ch.bezier_x, y: out_ch.bezier_y,
                                 z: out_ch.bezier_z, last: out_ch.last_of_run});
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d bezier points still due", $time, trk.due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // main sequence
  initial begin
    int sent;
    int kind;
    int len;
    in_gaps_on        = 1'b0;
    out_stalls_on     = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.curve_start <= 1'b0;
    in_ch.point_x     <= '0;
    in_ch.point_y     <= '0;
    in_ch.point_z     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // curve opened without a start mark, coordinate extremes
    send_point(1'b0, CMAX, CMIN, -1);
    send_point(1'b0, CMIN, CMAX, 0);
    send_point(1'b0, CMAX, CMAX, CMIN);
    send_point(1'b0, CMIN, CMIN, CMAX);
    send_point(1'b0, CMAX, 0, CMIN);
    send_point(1'b0, -1, CMAX, CMAX);
    // repeated start marks drop the window
    send_point(1'b1, 5, 6, 7);
    send_point(1'b1, -3, 9, 100);
    send_point(1'b0, 1, -1, 2);
    send_point(1'b0, -7, 13, -2);
    send_point(1'b0, 11, -5, 3);
    // short curves of one, two and three points
    send_point(1'b1, CMAX, CMAX, CMAX);
    send_point(1'b1, CMIN, 1, -1);
    send_point(1'b0, 2, CMIN, 0);
    send_point(1'b1, 4, 4, 4);
    send_point(1'b0, -4, CMAX, CMIN);
    send_point(1'b0, 9, 0, -9);
    // negative sums that need floor rounding
    send_point(1'b1, 1, -1, 5);
    send_point(1'b0, -1, 2, -5);
    send_point(1'b0, 3, -7, 1);
    send_point(1'b0, -5, 1, 1);
    send_point(1'b0, -1, -1, -1);
    send_point(1'b0, 2, -3, 4);

    // random curves, idling chosen per curve after a clean stretch
    sent = 0;
    while (sent < RAND_POINTS) begin
      in_gaps_on    = (sent >= 60) && ($urandom_range(0, 2) != 0);
      out_stalls_on = (sent >= 60) && ($urandom_range(0, 2) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 12)
        len = $urandom_range(1, 3);
      else if (kind < 85)
        len = $urandom_range(4, 10);
      else
        len = $urandom_range(11, 30);
      // a few curves carry on without a start mark
      send_curve(len, kind % 10 != 0);
      sent += len;
    end
    in_ch.valid <= 1'b0;

    // drain, then allow for the pipeline latency
    out_stalls_on = 1'b0;
    while (trk.due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d control points in %0d curves, %0d bezier points checked",
             trk.n_points, trk.n_curves, trk.n_checked);
    if (trk.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
